FILE: design/bfba_pkg.sv
package bfba_pkg;

	localparam int MAX_BINS  = 16;
	localparam int SIZE_BITS = 16;
	localparam int IDX_W     = $clog2(MAX_BINS);
	localparam int CNT_W     = $clog2(MAX_BINS + 1);
	localparam int LIMIT_W   = 17;
	localparam int STAT_W    = 2;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10000);

	localparam logic CMD_DEFINE = 1'b0;
	localparam logic CMD_PLACE  = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic             load_item;
		logic             scan_start;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             commit;
	} bfba_cmd_t;

	typedef struct packed {
		logic             item_place;
		logic [CNT_W-1:0] bins_n;
		logic             out_busy;
	} bfba_stat_t;

endpackage

FILE: design/bfba_ctrl.sv
module bfba_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  bfba_pkg::bfba_stat_t  stat,
	output bfba_pkg::bfba_cmd_t   cmd
);
	import bfba_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_WAIT,
		S_COMMIT
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;
	logic             last_idx;

	assign last_idx = (({1'b0, idx_q} + CNT_W'(1)) == stat.bins_n);
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.rd_addr    = idx_q;
		cmd.load_item  = (state_q == S_IDLE) && in_valid;
		cmd.scan_start = (state_q == S_DECODE);
		cmd.rd_en      = (state_q == S_SCAN);
		cmd.commit     = (state_q == S_COMMIT) && !stat.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DECODE;
				end
				S_DECODE: begin
					idx_q <= '0;
					if (stat.item_place && (stat.bins_n != '0)) state_q <= S_SCAN;
					else state_q <= S_COMMIT;
				end
				S_SCAN: begin
					if (last_idx) state_q <= S_WAIT;
					else idx_q <= idx_q + IDX_W'(1);
				end
				S_WAIT: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (!stat.out_busy) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: design/bfba_dp.sv
module bfba_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bfba_pkg::bfba_cmd_t               cmd,
	output bfba_pkg::bfba_stat_t              stat,
	input  logic                              in_kind,
	input  logic [bfba_pkg::SIZE_BITS-1:0]    in_cap,
	input  logic [bfba_pkg::SIZE_BITS-1:0]    in_size,
	input  logic                              cfg_we,
	input  logic [bfba_pkg::LIMIT_W-1:0]      cfg_wdata,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [bfba_pkg::IDX_W-1:0]        out_index,
	output logic [bfba_pkg::SIZE_BITS-1:0]    out_free,
	output logic [bfba_pkg::STAT_W-1:0]       out_status
);
	import bfba_pkg::*;

	logic [SIZE_BITS-1:0] free_mem [MAX_BINS];

	logic                 kind_q;
	logic [SIZE_BITS-1:0] val_q;
	logic [CNT_W-1:0]     count_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic [SIZE_BITS-1:0] rd_data_s1;
	logic [IDX_W-1:0]     rd_addr_s1;
	logic                 rd_valid_s1;
	logic [LIMIT_W-1:0]   best_free_q;
	logic [IDX_W-1:0]     best_q;
	logic                 found_q;

	logic                 better;
	logic                 table_full;
	logic [SIZE_BITS-1:0] placed_free;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic [SIZE_BITS-1:0] wr_data;

	assign better      = (rd_data_s1 >= val_q) && ({1'b0, rd_data_s1} < best_free_q);
	assign table_full  = (count_q == CNT_W'(MAX_BINS));
	assign placed_free = best_free_q[SIZE_BITS-1:0] - val_q;

	assign stat.item_place = (kind_q == CMD_PLACE);
	assign stat.bins_n     = count_q;
	assign stat.out_busy   = out_valid && !out_ready;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = best_q;
		wr_data = placed_free;
		if (cmd.commit) begin
			if (kind_q == CMD_DEFINE) begin
				wr_en   = !table_full;
				wr_addr = count_q[IDX_W-1:0];
				wr_data = val_q;
			end else begin
				wr_en = found_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) free_mem[wr_addr] <= wr_data;
		if (cmd.rd_en) rd_data_s1 <= free_mem[cmd.rd_addr];
		rd_addr_s1 <= cmd.rd_addr;
		if (cmd.load_item) begin
			kind_q <= in_kind;
			val_q  <= (in_kind == CMD_PLACE) ? in_size : in_cap;
		end
		if (cmd.scan_start) begin
			best_free_q <= limit_q;
			best_q      <= '0;
		end else if (rd_valid_s1 && better) begin
			best_free_q <= {1'b0, rd_data_s1};
			best_q      <= rd_addr_s1;
		end
		if (cmd.commit) begin
			if (kind_q == CMD_DEFINE) begin
				out_index  <= table_full ? '0 : count_q[IDX_W-1:0];
				out_free   <= table_full ? '0 : val_q;
				out_status <= table_full ? ST_FULL : ST_OK;
			end else begin
				out_index  <= found_q ? best_q : '0;
				out_free   <= found_q ? placed_free : '0;
				out_status <= found_q ? ST_OK : ST_NOFIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			limit_q     <= LIMIT_RESET;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (cfg_we) limit_q <= cfg_wdata;
			rd_valid_s1 <= cmd.rd_en;
			if (cmd.scan_start) found_q <= 1'b0;
			else if (rd_valid_s1 && better) found_q <= 1'b1;
			if (cmd.commit && (kind_q == CMD_DEFINE) && !table_full)
				count_q <= count_q + CNT_W'(1);
			if (cmd.commit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

endmodule

FILE: design/best_fit_bin_assigner.sv
// channel   dir  signals                         contents (low bit up)
// s_axis    in   s_tvalid s_tready s_tdata s_tuser  bin_capacity, item_size; cmd
// m_axis    out  m_tvalid m_tready m_tdata m_tuser  bin_index, free_after; status
// cfg       in   cfg_we cfg_wdata                free_space_limit
//
// A define goes from the transfer through decode to commit; a place with bins defined
// also scans them first, reading one stored bin per cycle from the free-space memory.
// One item is in work at a time; a new one is taken once the result sits in the
// output register. Reset clears the bin count and restores the limit to 10000.
// A stalled output holds the finished result and the next item waits before commit.
module best_fit_bin_assigner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // bin_capacity[15:0], item_size[31:16]
	input  logic [0:0]  s_tuser,   // cmd[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // bin_index[3:0], free_after[19:4], zero[23:20]
	output logic [1:0]  m_tuser,   // status[1:0]
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata
);
	import bfba_pkg::*;

	bfba_cmd_t            cmd;
	bfba_stat_t           stat;
	logic [IDX_W-1:0]     out_index;
	logic [SIZE_BITS-1:0] out_free;
	logic [STAT_W-1:0]    out_status;

	bfba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bfba_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_kind    (s_tuser[0]),
		.in_cap     (s_tdata[15:0]),
		.in_size    (s_tdata[31:16]),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_index  (out_index),
		.out_free   (out_free),
		.out_status (out_status)
	);

	assign m_tdata = {4'b0000, out_free, out_index};
	assign m_tuser = out_status;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_NOFIT || m_tuser == ST_FULL))
		else $error("bad status code");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item taken while busy");

	a_fail_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK) |-> (m_tdata[19:0] == 20'd0))
		else $error("failure result carries data");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.bins_n <= CNT_W'(MAX_BINS))
		else $error("bin count overflow");

endmodule
